>>> src/speed_pid_integral_clamp_defines.svh
// assertion macros for the speed pid controller checker
`ifndef SPEED_PID_INTEGRAL_CLAMP_DEFINES_SVH
`define SPEED_PID_INTEGRAL_CLAMP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define SPIC_ASSERT_NOW(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPIC_ASSERT_NEXT(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/spic_pkg.sv
// types and constants shared by the speed pid controller
`timescale 1ns / 1ps

package spic_pkg;

   typedef logic signed [15:0] gain_type;     // signed q8.8
   typedef logic signed [15:0] speed_type;    // signed q12.4
   typedef logic signed [16:0] err_type;      // signed q12.4, one bit of growth
   typedef logic signed [17:0] diff_type;     // error difference
   typedef logic        [14:0] limit_type;    // unsigned q11.4
   typedef logic        [1:0]  csr_idx_type;
   typedef logic        [31:0] drive_type;    // signed q.4

   localparam csr_idx_type CSR_PROP_GAIN      = 2'd0;
   localparam csr_idx_type CSR_INTEG_GAIN     = 2'd1;
   localparam csr_idx_type CSR_DERIV_GAIN     = 2'd2;
   localparam csr_idx_type CSR_INTEGRAL_LIMIT = 2'd3;

   localparam limit_type LIMIT_RESET = 15'd1600;   // 100.0 in q12.4

endpackage

>>> src/spic_integrator.sv
// error, clamped integral and error difference stage
`timescale 1ns / 1ps

module spic_integrator (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  spic_pkg::speed_type measured_speed,
   input  spic_pkg::speed_type target_speed,
   input  spic_pkg::limit_type integral_limit,
   output spic_pkg::err_type   error_out,
   output spic_pkg::err_type   error_sum_out,
   output spic_pkg::diff_type  error_diff_out
);
   import spic_pkg::*;

   // err_ff doubles as the previous error for the next beat
   err_type            err_ff,  err_in;
   err_type            sum_ff,  sum_in;
   diff_type           diff_ff, diff_in;
   logic signed [17:0] sum_raw;
   logic signed [17:0] lim_pos;
   logic signed [17:0] lim_neg;
   logic signed [17:0] sum_clamped;

   always_comb begin
      err_in  = {target_speed[15], target_speed} - {measured_speed[15], measured_speed};
      sum_raw = {sum_ff[16], sum_ff} + {err_in[16], err_in};
      lim_pos = {3'b000, integral_limit};
      lim_neg = -lim_pos;
      priority if (sum_raw > lim_pos) begin
         sum_clamped = lim_pos;
      end else if (sum_raw < lim_neg) begin
         sum_clamped = lim_neg;
      end else begin
         sum_clamped = sum_raw;
      end
      // clamped value always fits 17 bits since the limit is below 2^15
      sum_in  = sum_clamped[16:0];
      diff_in = {err_in[16], err_in} - {err_ff[16], err_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         sum_ff <= '0;
      end else if (step) begin
         err_ff <= err_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         diff_ff <= diff_in;
      end
   end

   assign error_out      = err_ff;
   assign error_sum_out  = sum_ff;
   assign error_diff_out = diff_ff;

endmodule

>>> src/speed_pid_integral_clamp.sv
// speed pid controller with clamped integral, top level
//
//   channel | dir | fields (low bit first)
//   --------+-----+--------------------------------------------------
//   req     | in  | tdata: measured_speed[15:0], target_speed[31:16]
//   rsp     | out | tdata: drive_value[31:0]
//   csr     | in  | index 0 prop, 1 integ, 2 deriv gain, 3 integral limit
//
// four register stages: input, integrator, products, rounded result.
// one beat per cycle while rsp is not stalled; beats pass the stages in that order.
// integral and previous error live in the integrator stage and update as
// each beat leaves the input register; reset clears them and the gains.
// a stalled rsp only holds stages that are full, so empty stages keep taking beats.
`timescale 1ns / 1ps

module speed_pid_integral_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // measured_speed, target_speed
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // drive_value
   input  logic                  csr_we,
   input  spic_pkg::csr_idx_type csr_index,
   input  logic [15:0]           csr_wdata
);
   import spic_pkg::*;

   gain_type  prop_gain_ff;
   gain_type  integ_gain_ff;
   gain_type  deriv_gain_ff;
   limit_type limit_ff;

   speed_type meas_ff;
   speed_type targ_ff;
   logic      in_valid_ff;
   logic      int_valid_ff;
   logic      mul_valid_ff;
   logic      rsp_valid_ff;

   err_type   err;
   err_type   err_sum;
   diff_type  err_diff;

   logic signed [32:0] prop_prod_ff,  prop_prod_in;
   logic signed [32:0] integ_prod_ff, integ_prod_in;
   logic signed [33:0] deriv_prod_ff, deriv_prod_in;
   logic signed [35:0] acc;
   logic signed [35:0] acc_rnd;
   drive_type          drive_ff, drive_in;

   logic rsp_go;
   logic mul_go;
   logic int_go;
   logic in_go;

   // a stage loads when it is empty or the stage after it moves
   assign rsp_go = !rsp_valid_ff || rsp_tready;
   assign mul_go = !mul_valid_ff || rsp_go;
   assign int_go = !int_valid_ff || mul_go;
   assign in_go  = !in_valid_ff  || int_go;

   assign req_tready = in_go;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:      prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN:     integ_gain_ff <= csr_wdata;
            CSR_DERIV_GAIN:     deriv_gain_ff <= csr_wdata;
            CSR_INTEGRAL_LIMIT: limit_ff      <= csr_wdata[14:0];
            default:            limit_ff      <= limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         int_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_go) begin
            in_valid_ff <= req_tvalid;
         end
         if (int_go) begin
            int_valid_ff <= in_valid_ff;
         end
         if (mul_go) begin
            mul_valid_ff <= int_valid_ff;
         end
         if (rsp_go) begin
            rsp_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_go && req_tvalid) begin
         meas_ff <= req_tdata[15:0];
         targ_ff <= req_tdata[31:16];
      end
   end

   spic_integrator u_integrator (
      .clock          (clock),
      .reset          (reset),
      .step           (int_go && in_valid_ff),
      .measured_speed (meas_ff),
      .target_speed   (targ_ff),
      .integral_limit (limit_ff),
      .error_out      (err),
      .error_sum_out  (err_sum),
      .error_diff_out (err_diff)
   );

   assign prop_prod_in  = prop_gain_ff * err;
   assign integ_prod_in = integ_gain_ff * err_sum;
   assign deriv_prod_in = deriv_gain_ff * err_diff;

   always_ff @(posedge clock) begin
      if (mul_go && int_valid_ff) begin
         prop_prod_ff  <= prop_prod_in;
         integ_prod_ff <= integ_prod_in;
         deriv_prod_ff <= deriv_prod_in;
      end
   end

   // sum stays below 2^34 in magnitude, so the rounded q.4 value always fits
   // 32 bits, with no saturation needed
   always_comb begin
      acc = {{3{prop_prod_ff[32]}}, prop_prod_ff}
          + {{3{integ_prod_ff[32]}}, integ_prod_ff}
          + {{2{deriv_prod_ff[33]}}, deriv_prod_ff};
      acc_rnd  = acc + 36'sd128;
      drive_in = {{4{acc_rnd[35]}}, acc_rnd[35:8]};
   end

   always_ff @(posedge clock) begin
      if (rsp_go && mul_valid_ff) begin
         drive_ff <= drive_in;
      end
   end

endmodule

>>> src/spic_checker.sv
// port-level checker for the speed pid controller, bound to the top level
`timescale 1ns / 1ps
`include "speed_pid_integral_clamp_defines.svh"

module spic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a waiting result keeps its beat
   `SPIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // the input side only backs up once every stage is full and rsp is blocked
   `SPIC_ASSERT_NOW(a_req_stall_cause, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready, "req stalled with room in the pipeline")

   // reset empties the pipeline
   `SPIC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset,
      !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind speed_pid_integral_clamp spic_checker u_spic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
